// File: hdl/euler_to_quaternion_assert.svh
// Assertion macros for the euler_to_quaternion block.
// Define SYNTH to compile them away.
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

`ifndef SYNTH
// ante in this cycle requires cons in the same cycle
`define E2Q_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// ante in this cycle requires cons in the next cycle
`define E2Q_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define E2Q_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define E2Q_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/e2q_pkg.sv
`timescale 1ns / 1ps

package e2q_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int OUT_BITS   = 16;

	localparam int NAX = 3;        // roll, pitch, yaw
	localparam int NQ  = 4;        // x, y, z, w

	localparam int AX_ROLL  = 0;
	localparam int AX_PITCH = 1;
	localparam int AX_YAW   = 2;

	localparam int Q_X = 0;
	localparam int Q_Y = 1;
	localparam int Q_Z = 2;
	localparam int Q_W = 3;

	localparam int IN_W  = ((NAX * ANGLE_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((NQ * OUT_BITS + 7) / 8) * 8;

	// CORDIC datapath: Q30 sine/cosine, angles at 2^32 counts per turn
	localparam int CW            = 32;
	localparam int PW            = 64;
	localparam int CORDIC_ITERS  = 30;
	localparam int ITERS_PER_STG = 2;
	localparam int NSTG          = CORDIC_ITERS / ITERS_PER_STG;
	localparam int IDX_W         = $clog2(CORDIC_ITERS);

	typedef logic signed [CW-1:0] cw_t;
	typedef logic signed [PW-1:0] pw_t;
	typedef cw_t [NAX-1:0] cw_vec_t;
	typedef pw_t [NQ-1:0]  quat_sum_t;

	typedef struct packed {
		cw_t x;
		cw_t y;
		cw_t z;
	} cstate_t;

	localparam cw_t CORDIC_GAIN = 32'sd652032874;

	localparam cw_t ATAN_TAB [CORDIC_ITERS] = '{
		32'sh20000000, 32'sh12E4051D, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
		32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2E,
		32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9,
		32'sh0000517C, 32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
		32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051, 32'sh00000028,
		32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000002, 32'sh00000001
	};

	// half angle scaling into 2^32 counts per turn
	localparam int HA_L = (ANGLE_BITS <= 31) ? (31 - ANGLE_BITS) : 0;
	localparam int HA_R = (ANGLE_BITS > 31) ? (ANGLE_BITS - 31) : 0;

	// rounding of the yaw*pitch product back to Q30
	localparam int  AB_SH  = 30;
	localparam pw_t AB_RND = pw_t'(64'sd1 <<< (AB_SH - 1));

	// final Q60 to Q1.(OUT_BITS-1)
	localparam int  OUT_SH  = 61 - OUT_BITS;
	localparam pw_t OUT_RND = pw_t'(64'sd1 <<< (OUT_SH - 1));
	localparam pw_t OUT_MAX = pw_t'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
	localparam pw_t OUT_MIN = pw_t'(-(64'sd1 <<< (OUT_BITS - 1)));

	function automatic cw_t half_angle(logic signed [ANGLE_BITS-1:0] a);
		cw_t e;
		e = cw_t'(a);
		return (e <<< HA_L) >>> HA_R;
	endfunction

	// one rotation-mode micro-rotation
	function automatic cstate_t cordic_step(cstate_t c, logic [IDX_W-1:0] i);
		cstate_t r;
		cw_t     dx;
		cw_t     dy;
		dx = c.x;
		dy = c.y;
		dx = dy >>> i;
		dy = c.x >>> i;
		if (!c.z[CW-1]) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - ATAN_TAB[i];
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + ATAN_TAB[i];
		end
		return r;
	endfunction

	function automatic logic signed [OUT_BITS-1:0] sat_out(pw_t sum);
		pw_t v;
		v = (sum + OUT_RND) >>> OUT_SH;
		if (v > OUT_MAX) begin
			v = OUT_MAX;
		end
		if (v < OUT_MIN) begin
			v = OUT_MIN;
		end
		return v[OUT_BITS-1:0];
	endfunction

endpackage

// File: hdl/e2q_cordic.sv
`timescale 1ns / 1ps

module e2q_cordic
	import e2q_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  cw_vec_t z_in,
	output logic    out_valid,
	output cw_vec_t sin_out,
	output cw_vec_t cos_out
);

	cstate_t    cord_s [NSTG][NAX];
	logic [NSTG-1:0] v_s;

	for (genvar g = 0; g < NSTG; g++) begin : g_stg
		cstate_t prev [NAX];
		cstate_t mid  [NAX];
		cstate_t nxt  [NAX];

		if (g == 0) begin : g_first
			always_comb begin
				for (int a = 0; a < NAX; a++) begin
					prev[a].x = CORDIC_GAIN;
					prev[a].y = '0;
					prev[a].z = z_in[a];
				end
			end
		end else begin : g_rest
			always_comb begin
				for (int a = 0; a < NAX; a++) begin
					prev[a] = cord_s[g-1][a];
				end
			end
		end

		always_comb begin
			for (int a = 0; a < NAX; a++) begin
				mid[a] = cordic_step(prev[a], IDX_W'(ITERS_PER_STG * g));
				nxt[a] = cordic_step(mid[a], IDX_W'(ITERS_PER_STG * g + 1));
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int a = 0; a < NAX; a++) begin
					cord_s[g][a] <= nxt[a];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= (g == 0) ? in_valid : v_s[(g == 0) ? 0 : g-1];
			end
		end
	end

	assign out_valid = v_s[NSTG-1];

	always_comb begin
		for (int a = 0; a < NAX; a++) begin
			sin_out[a] = cord_s[NSTG-1][a].y;
			cos_out[a] = cord_s[NSTG-1][a].x;
		end
	end

endmodule

// File: hdl/e2q_combine.sv
`timescale 1ns / 1ps

module e2q_combine
	import e2q_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  cw_vec_t   sin_in,
	input  cw_vec_t   cos_in,
	output logic      out_valid,
	output quat_sum_t sum_out
);

	localparam int PR_CC = 0;   // cy*cp
	localparam int PR_SS = 1;   // sy*sp
	localparam int PR_SC = 2;   // sy*cp
	localparam int PR_CS = 3;   // cy*sp
	localparam int NPR   = 4;
	localparam int NT    = 2 * NQ;

	pw_t ab_s1 [NPR];
	cw_t sr_s1;
	cw_t cr_s1;
	cw_t ab_s2 [NPR];
	cw_t sr_s2;
	cw_t cr_s2;
	pw_t t_s3  [NT];
	quat_sum_t sum_s4;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			// yaw by pitch products
			ab_s1[PR_CC] <= pw_t'(cos_in[AX_YAW]) * pw_t'(cos_in[AX_PITCH]);
			ab_s1[PR_SS] <= pw_t'(sin_in[AX_YAW]) * pw_t'(sin_in[AX_PITCH]);
			ab_s1[PR_SC] <= pw_t'(sin_in[AX_YAW]) * pw_t'(cos_in[AX_PITCH]);
			ab_s1[PR_CS] <= pw_t'(cos_in[AX_YAW]) * pw_t'(sin_in[AX_PITCH]);
			sr_s1 <= sin_in[AX_ROLL];
			cr_s1 <= cos_in[AX_ROLL];

			// round back to Q30
			for (int k = 0; k < NPR; k++) begin
				ab_s2[k] <= cw_t'((ab_s1[k] + AB_RND) >>> AB_SH);
			end
			sr_s2 <= sr_s1;
			cr_s2 <= cr_s1;

			// times the roll factor
			t_s3[2*Q_X]     <= pw_t'(ab_s2[PR_CC]) * pw_t'(sr_s2);
			t_s3[2*Q_X + 1] <= pw_t'(ab_s2[PR_SS]) * pw_t'(cr_s2);
			t_s3[2*Q_Y]     <= pw_t'(ab_s2[PR_SC]) * pw_t'(sr_s2);
			t_s3[2*Q_Y + 1] <= pw_t'(ab_s2[PR_CS]) * pw_t'(cr_s2);
			t_s3[2*Q_Z]     <= pw_t'(ab_s2[PR_SC]) * pw_t'(cr_s2);
			t_s3[2*Q_Z + 1] <= pw_t'(ab_s2[PR_CS]) * pw_t'(sr_s2);
			t_s3[2*Q_W]     <= pw_t'(ab_s2[PR_CC]) * pw_t'(cr_s2);
			t_s3[2*Q_W + 1] <= pw_t'(ab_s2[PR_SS]) * pw_t'(sr_s2);

			sum_s4[Q_X] <= t_s3[2*Q_X] - t_s3[2*Q_X + 1];
			sum_s4[Q_Y] <= t_s3[2*Q_Y] + t_s3[2*Q_Y + 1];
			sum_s4[Q_Z] <= t_s3[2*Q_Z] - t_s3[2*Q_Z + 1];
			sum_s4[Q_W] <= t_s3[2*Q_W] + t_s3[2*Q_W + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_valid = v_s4;
	assign sum_out   = sum_s4;

endmodule

// File: hdl/euler_to_quaternion.sv
// Z-Y-X Euler angles (binary angles) to a Q1.15 unit quaternion.
// Path from the accepting edge to m_tvalid: half-angle register, 15 two-iteration
// CORDIC stages, 4 combine stages (multiply, round, multiply, add), output register.
// Throughput: one word per cycle while the output is not stalled.
// A stalled output holds; the pipeline advances until a word reaches its last stage.
// Reset (arst_n low, asynchronous) clears every valid bit; data registers are not reset.
`timescale 1ns / 1ps

`include "euler_to_quaternion_assert.svh"

module euler_to_quaternion
	import e2q_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// s_tdata: roll_angle, pitch_angle, yaw_angle (lowest bits first), zero fill on top
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	// m_tdata: quat_x, quat_y, quat_z, quat_w (lowest bits first), zero fill on top
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	// Stage 1: register the half angles.
	cw_vec_t z_s1;
	logic    v_s1;

	// CORDIC results and combine results
	logic      cord_valid;
	cw_vec_t   sin_w;
	cw_vec_t   cos_w;
	logic      sum_valid;
	quat_sum_t sum_w;

	// output register
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic [OUT_W-1:0] out_pack;

	logic out_load;
	logic adv;

	// The output register takes a word whenever it is empty or being drained.
	assign out_load = !out_valid_q || m_tready;

	// Advance the pipeline unless its last stage holds a word that the output
	// register cannot take; a waiting result does not block an empty tail.
	assign adv = !(sum_valid && !out_load);

	assign s_tready = adv;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < NAX; a++) begin
				z_s1[a] <= half_angle(s_tdata[a*ANGLE_BITS +: ANGLE_BITS]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	e2q_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s1),
		.z_in      (z_s1),
		.out_valid (cord_valid),
		.sin_out   (sin_w),
		.cos_out   (cos_w)
	);

	e2q_combine u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (cord_valid),
		.sin_in    (sin_w),
		.cos_in    (cos_w),
		.out_valid (sum_valid),
		.sum_out   (sum_w)
	);

	// Round, saturate and pack the four parts; pad bits stay zero.
	always_comb begin
		out_pack = '0;
		for (int q = 0; q < NQ; q++) begin
			out_pack[q*OUT_BITS +: OUT_BITS] = sat_out(sum_w[q]);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_pack;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= sum_valid;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// a word in the last stage that meets a full, stalled output must stay there
	`E2Q_ASSERT_NEXT(a_tail_held, clk, arst_n, sum_valid && out_valid_q && !m_tready, sum_valid)
	// an accepted word always lands in stage 1
	`E2Q_ASSERT_NEXT(a_in_lands, clk, arst_n, s_tvalid && s_tready, v_s1)
	// the input side only stalls while the output holds an untaken word
	`E2Q_ASSERT_SAME(a_stall_cause, clk, arst_n, !s_tready, out_valid_q && !m_tready && sum_valid)

endmodule
